FILE: sv/xcfr_pkg.sv
`default_nettype none
package xcfr_pkg;

    localparam int PacketBytes = 128;
    localparam int WordCount   = PacketBytes / 4;
    localparam int StoreAw     = $clog2(PacketBytes);
    localparam int WordAw      = $clog2(WordCount);
    localparam logic [3:0] RetryLimit = 4'd5;

    localparam logic [7:0] ChSoh = 8'h01;
    localparam logic [7:0] ChEot = 8'h04;
    localparam logic [7:0] ChAck = 8'h06;
    localparam logic [7:0] ChNak = 8'h15;
    localparam logic [7:0] ChCan = 8'h18;

    localparam logic [1:0] KindStart   = 2'd0;
    localparam logic [1:0] KindByte    = 2'd1;
    localparam logic [1:0] KindTimeout = 2'd2;
    localparam logic [1:0] KindFinish  = 2'd3;

    localparam logic [1:0] OutTx    = 2'd0;
    localparam logic [1:0] OutErase = 2'd1;
    localparam logic [1:0] OutWrite = 2'd2;
    localparam logic [1:0] OutEnd   = 2'd3;

    localparam logic [1:0] StRun     = 2'd0;
    localparam logic [1:0] StSuccess = 2'd1;
    localparam logic [1:0] StCan     = 2'd2;
    localparam logic [1:0] StGaveUp  = 2'd3;

    localparam logic [1:0] CauseNone  = 2'd0;
    localparam logic [1:0] CauseSize  = 2'd1;
    localparam logic [1:0] CauseAddr  = 2'd2;
    localparam logic [1:0] CauseRetry = 2'd3;

    localparam logic [1:0] RegStart = 2'd0;
    localparam logic [1:0] RegEnd   = 2'd1;
    localparam logic [1:0] RegShift = 2'd2;

    // tdata layout of a result
    typedef struct packed {
        logic [1:0]  error_cause;
        logic [1:0]  status;
        logic [31:0] write_word;
        logic [31:0] write_addr;
        logic [24:0] sector_index;
        logic [7:0]  tx_byte;
        logic [1:0]  out_kind;
    } result_t;

    // controller -> datapath commands
    typedef struct packed {
        logic session_start;   // load pointers from start_addr
        logic hdr_take_pid;
        logic data_take;       // store byte, update crc
        logic crc1_take;
        logic retry_inc;
        logic retry_clr;
        logic enter_data;
        logic exp_inc;
        logic packet_commit;   // advance write pointer, head taken
        logic sector_take;
        logic head_take0;
        logic head_take1;
        logic rd_en;
        logic [WordAw-1:0] rd_word;
    } cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic pid_ok;        // packet number matches complement
        logic crc_ok;
        logic last_data;
        logic num_is_zero;
        logic num_is_exp;
        logic size_ok;
        logic addr_ok;
        logic sector_new;
        logic retry_over;
        logic in_data;
        logic head_taken;
    } stat_t;

endpackage
`default_nettype wire

FILE: sv/xcfr_datapath.sv
`default_nettype none
module xcfr_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_idx,
    input  wire logic [31:0]          cfg_val,
    input  wire logic [7:0]           rx_byte,
    input  wire xcfr_pkg::cmd_t       cmd,
    output xcfr_pkg::stat_t           stat,
    output logic [31:0]               rd_data,
    output logic [31:0]               wptr,
    output logic [24:0]               sector,
    output logic [31:0]               head_addr,
    output logic [31:0]               head_w0,
    output logic [31:0]               head_w1
);

    logic [31:0] start_reg, end_reg;
    logic [4:0]  shift_reg;
    logic [7:0]  bcnt_reg, pnum_reg, exp_reg, crch_reg;
    logic [15:0] crc_reg, crc_next;
    logic [3:0]  retry_reg;
    logic [31:0] wptr_reg, prior_reg, hadr_reg, hw0_reg, hw1_reg;
    logic        indata_reg, htaken_reg;
    logic [7:0]  store0 [xcfr_pkg::WordCount];
    logic [7:0]  store1 [xcfr_pkg::WordCount];
    logic [7:0]  store2 [xcfr_pkg::WordCount];
    logic [7:0]  store3 [xcfr_pkg::WordCount];
    logic [31:0] sec_full;
    logic [31:0] word0_reg;

    always_comb
    begin
        logic [15:0] c;
        c = crc_reg ^ {rx_byte, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        end
        crc_next = c;
    end

    assign sec_full = wptr_reg >> shift_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.data_take)
        begin
            unique case (bcnt_reg[1:0])
                2'd0: store0[bcnt_reg[xcfr_pkg::StoreAw-1:2]] <= rx_byte;
                2'd1: store1[bcnt_reg[xcfr_pkg::StoreAw-1:2]] <= rx_byte;
                2'd2: store2[bcnt_reg[xcfr_pkg::StoreAw-1:2]] <= rx_byte;
                default: store3[bcnt_reg[xcfr_pkg::StoreAw-1:2]] <= rx_byte;
            endcase
        end
        if (cmd.rd_en)
        begin
            rd_data <= {store3[cmd.rd_word], store2[cmd.rd_word],
                        store1[cmd.rd_word], store0[cmd.rd_word]};
        end
    end

    // word 0 kept aside for the size check of packet 0
    always_ff @(posedge clk)
    begin
        if (cmd.data_take && bcnt_reg[xcfr_pkg::StoreAw-1:2] == '0)
        begin
            unique case (bcnt_reg[1:0])
                2'd0: word0_reg[7:0]   <= rx_byte;
                2'd1: word0_reg[15:8]  <= rx_byte;
                2'd2: word0_reg[23:16] <= rx_byte;
                default: word0_reg[31:24] <= rx_byte;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= '0;
            end_reg    <= '0;
            shift_reg  <= 5'd10;
            bcnt_reg   <= '0;
            pnum_reg   <= 8'hFF;
            exp_reg    <= '0;
            crc_reg    <= '0;
            crch_reg   <= '0;
            retry_reg  <= '0;
            wptr_reg   <= '0;
            prior_reg  <= '0;
            hadr_reg   <= '0;
            hw0_reg    <= '0;
            hw1_reg    <= '0;
            indata_reg <= 1'b0;
            htaken_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    xcfr_pkg::RegStart: start_reg <= cfg_val;
                    xcfr_pkg::RegEnd:   end_reg   <= cfg_val;
                    xcfr_pkg::RegShift: shift_reg <= cfg_val[4:0];
                    default: ;
                endcase
            end
            if (cmd.session_start)
            begin
                indata_reg <= 1'b0;
                retry_reg  <= '0;
                exp_reg    <= '0;
                wptr_reg   <= start_reg;
                hadr_reg   <= start_reg;
                prior_reg  <= '0;
                htaken_reg <= 1'b0;
            end
            if (cmd.hdr_take_pid)
            begin
                pnum_reg <= rx_byte;
                bcnt_reg <= '0;
                crc_reg  <= '0;
            end
            if (cmd.data_take)
            begin
                crc_reg  <= crc_next;
                bcnt_reg <= bcnt_reg + 8'd1;
            end
            if (cmd.crc1_take)
                crch_reg <= rx_byte;
            if (cmd.retry_clr)
                retry_reg <= '0;
            else if (cmd.retry_inc && retry_reg != 4'hF)
                retry_reg <= retry_reg + 4'd1;
            if (cmd.enter_data)
            begin
                indata_reg <= 1'b1;
                exp_reg    <= 8'd1;
            end
            if (cmd.exp_inc)
                exp_reg <= exp_reg + 8'd1;
            if (cmd.sector_take)
                prior_reg <= sec_full;
            if (cmd.head_take0)
                hw0_reg <= rd_data;
            if (cmd.head_take1)
                hw1_reg <= rd_data;
            if (cmd.packet_commit)
            begin
                wptr_reg   <= wptr_reg + 32'(xcfr_pkg::PacketBytes);
                htaken_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        stat.pid_ok      = (pnum_reg == ~rx_byte);
        stat.crc_ok      = (crch_reg == crc_reg[15:8]) && (rx_byte == crc_reg[7:0]);
        stat.last_data   = (bcnt_reg == 8'(xcfr_pkg::PacketBytes - 1));
        stat.num_is_zero = (pnum_reg == 8'd0);
        stat.num_is_exp  = (pnum_reg == exp_reg);
        stat.size_ok     = !(word0_reg > (end_reg - start_reg));
        stat.addr_ok     = !((wptr_reg + 32'(xcfr_pkg::PacketBytes)) > end_reg);
        stat.sector_new  = (sec_full != prior_reg);
        stat.retry_over  = (retry_reg >= xcfr_pkg::RetryLimit);
        stat.in_data     = indata_reg;
        stat.head_taken  = htaken_reg;
    end

    assign wptr      = wptr_reg;
    assign sector    = sec_full[24:0];
    assign head_addr = hadr_reg;
    assign head_w0   = hw0_reg;
    assign head_w1   = hw1_reg;

`ifndef NO_ASSERTIONS
    a_bcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.data_take |-> bcnt_reg < 8'(xcfr_pkg::PacketBytes))
        else $error("byte count past packet");
    a_commit_adv: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.packet_commit && !cmd.session_start
        |=> wptr_reg == $past(wptr_reg) + 32'(xcfr_pkg::PacketBytes))
        else $error("write pointer not advanced");
    a_head_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.head_take0 |-> !htaken_reg)
        else $error("head word taken twice");
`endif

endmodule
`default_nettype wire

FILE: sv/xcfr_ctrl.sv
`default_nettype none
module xcfr_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           kind,
    input  wire logic [7:0]           rx_byte,
    input  wire xcfr_pkg::stat_t      stat,
    output xcfr_pkg::cmd_t            cmd,
    input  wire logic [31:0]          rd_data,
    input  wire logic [31:0]          wptr,
    input  wire logic [24:0]          sector,
    input  wire logic [31:0]          head_addr,
    input  wire logic [31:0]          head_w0,
    input  wire logic [31:0]          head_w1,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output xcfr_pkg::result_t         out_data,
    output logic                      out_last
);

    typedef enum logic [7:0] {
        PH_IDLE  = 8'b0000_0001,
        PH_HDR   = 8'b0000_0010,
        PH_PID   = 8'b0000_0100,
        PH_IPID  = 8'b0000_1000,
        PH_DATA  = 8'b0001_0000,
        PH_CRC1  = 8'b0010_0000,
        PH_CRC2  = 8'b0100_0000,
        PH_DRAIN = 8'b1000_0000
    } phase_t;

    typedef enum logic [4:0] {
        SQ_NONE  = 5'b00001,
        SQ_WORDS = 5'b00010,
        SQ_ACK   = 5'b00100,
        SQ_HEAD1 = 5'b01000,
        SQ_FAIL  = 5'b10000
    } seq_t;

    phase_t phase_reg, phase_next;
    seq_t   seq_reg, seq_next;
    logic [xcfr_pkg::WordAw:0] widx_reg, widx_next;
    logic   rd_ok_reg, rd_ok_next;
    logic [1:0] fcause_reg, fcause_next;
    logic   ov_reg, ov_next, last_reg, last_next;
    xcfr_pkg::result_t od_reg, od_next;
    logic   take, space;

    assign space    = !ov_reg || out_ready;
    assign in_ready = (seq_reg == SQ_NONE) && space;
    assign take     = in_valid && in_ready;

    function automatic xcfr_pkg::result_t mk(input logic [1:0] k, input logic [7:0] tx,
        input logic [24:0] sec, input logic [31:0] a, input logic [31:0] w,
        input logic [1:0] st, input logic [1:0] ca);
        xcfr_pkg::result_t r;
        r.out_kind = k; r.tx_byte = tx; r.sector_index = sec;
        r.write_addr = a; r.write_word = w; r.status = st; r.error_cause = ca;
        return r;
    endfunction

    always_comb
    begin
        logic emit;
        phase_next  = phase_reg;
        seq_next    = seq_reg;
        widx_next   = widx_reg;
        rd_ok_next  = 1'b0;
        fcause_next = fcause_reg;
        cmd         = '0;
        emit        = 1'b0;
        od_next     = od_reg;
        last_next   = last_reg;
        unique case (seq_reg)
            SQ_NONE:
            begin
                if (take)
                begin
                    unique case (kind)
                        xcfr_pkg::KindStart:
                        begin
                            cmd.session_start = 1'b1;
                            phase_next = PH_HDR;
                            emit = 1'b1; last_next = 1'b1;
                            od_next = mk(xcfr_pkg::OutTx, xcfr_pkg::ChNak, '0, '0, '0,
                                xcfr_pkg::StRun, xcfr_pkg::CauseNone);
                        end
                        xcfr_pkg::KindFinish:
                        begin
                            emit = 1'b1; last_next = 1'b0;
                            od_next = mk(xcfr_pkg::OutWrite, '0, '0, head_addr, head_w0,
                                xcfr_pkg::StRun, xcfr_pkg::CauseNone);
                            seq_next = SQ_HEAD1;
                        end
                        xcfr_pkg::KindTimeout:
                        begin
                            priority case (1'b1)
                                phase_reg == PH_IDLE: ;
                                phase_reg != PH_DRAIN: phase_next = PH_DRAIN;
                                stat.retry_over:
                                begin
                                    cmd.retry_inc = 1'b1;
                                    phase_next = PH_IDLE;
                                    emit = 1'b1;
                                    if (stat.in_data)
                                    begin
                                        last_next = 1'b0;
                                        fcause_next = xcfr_pkg::CauseRetry;
                                        seq_next = SQ_FAIL;
                                        od_next = mk(xcfr_pkg::OutTx, xcfr_pkg::ChCan, '0,
                                            '0, '0, xcfr_pkg::StRun, xcfr_pkg::CauseNone);
                                    end
                                    else
                                    begin
                                        last_next = 1'b1;
                                        od_next = mk(xcfr_pkg::OutEnd, '0, '0, '0, '0,
                                            xcfr_pkg::StGaveUp, xcfr_pkg::CauseRetry);
                                    end
                                end
                                default:
                                begin
                                    cmd.retry_inc = 1'b1;
                                    phase_next = PH_HDR;
                                    emit = 1'b1; last_next = 1'b1;
                                    od_next = mk(xcfr_pkg::OutTx, xcfr_pkg::ChNak, '0, '0,
                                        '0, xcfr_pkg::StRun, xcfr_pkg::CauseNone);
                                end
                            endcase
                        end
                        default:
                        begin
                            unique case (phase_reg)
                                PH_HDR:
                                begin
                                    if (rx_byte == xcfr_pkg::ChSoh)
                                        phase_next = PH_PID;
                                    else if (rx_byte == xcfr_pkg::ChEot && stat.in_data)
                                    begin
                                        phase_next = PH_IDLE;
                                        emit = 1'b1; last_next = 1'b0;
                                        fcause_next = xcfr_pkg::CauseNone;
                                        seq_next = SQ_FAIL;
                                        od_next = mk(xcfr_pkg::OutTx, xcfr_pkg::ChAck, '0,
                                            '0, '0, xcfr_pkg::StRun, xcfr_pkg::CauseNone);
                                    end
                                    else
                                        phase_next = PH_DRAIN;
                                end
                                PH_PID:
                                begin
                                    cmd.hdr_take_pid = 1'b1;
                                    phase_next = PH_IPID;
                                end
                                PH_IPID:
                                    phase_next = stat.pid_ok ? PH_DATA : PH_DRAIN;
                                PH_DATA:
                                begin
                                    cmd.data_take = 1'b1;
                                    if (stat.last_data)
                                        phase_next = PH_CRC1;
                                end
                                PH_CRC1:
                                begin
                                    cmd.crc1_take = 1'b1;
                                    phase_next = PH_CRC2;
                                end
                                PH_CRC2:
                                begin
                                    priority if (!stat.crc_ok)
                                        phase_next = PH_DRAIN;
                                    else if (!stat.in_data)
                                    begin
                                        if (!stat.num_is_zero)
                                            phase_next = PH_DRAIN;
                                        else if (!stat.size_ok)
                                        begin
                                            phase_next = PH_IDLE;
                                            emit = 1'b1; last_next = 1'b0;
                                            fcause_next = xcfr_pkg::CauseSize;
                                            seq_next = SQ_FAIL;
                                            od_next = mk(xcfr_pkg::OutTx, xcfr_pkg::ChCan,
                                                '0, '0, '0, xcfr_pkg::StRun,
                                                xcfr_pkg::CauseNone);
                                        end
                                        else
                                        begin
                                            cmd.enter_data = 1'b1;
                                            cmd.retry_clr = 1'b1;
                                            phase_next = PH_HDR;
                                            emit = 1'b1; last_next = 1'b1;
                                            od_next = mk(xcfr_pkg::OutTx, xcfr_pkg::ChAck,
                                                '0, '0, '0, xcfr_pkg::StRun,
                                                xcfr_pkg::CauseNone);
                                        end
                                    end
                                    else if (!stat.num_is_exp)
                                        phase_next = PH_DRAIN;
                                    else if (!stat.addr_ok)
                                    begin
                                        phase_next = PH_IDLE;
                                        emit = 1'b1; last_next = 1'b0;
                                        fcause_next = xcfr_pkg::CauseAddr;
                                        seq_next = SQ_FAIL;
                                        od_next = mk(xcfr_pkg::OutTx, xcfr_pkg::ChCan, '0,
                                            '0, '0, xcfr_pkg::StRun, xcfr_pkg::CauseNone);
                                    end
                                    else
                                    begin
                                        phase_next = PH_HDR;
                                        seq_next = SQ_WORDS;
                                        widx_next = '0;
                                        cmd.rd_en = 1'b1;
                                        cmd.rd_word = '0;
                                        rd_ok_next = 1'b1;
                                        if (stat.sector_new)
                                        begin
                                            cmd.sector_take = 1'b1;
                                            emit = 1'b1; last_next = 1'b0;
                                            od_next = mk(xcfr_pkg::OutErase, '0, sector,
                                                '0, '0, xcfr_pkg::StRun,
                                                xcfr_pkg::CauseNone);
                                        end
                                    end
                                end
                                default: ;
                            endcase
                        end
                    endcase
                end
            end
            SQ_WORDS:
            begin
                // read data for widx is valid when rd_ok_reg is set
                if (rd_ok_reg && space)
                begin
                    emit = 1'b1; last_next = 1'b0;
                    od_next = mk(xcfr_pkg::OutWrite, '0, '0,
                        wptr + {25'd0, widx_reg[xcfr_pkg::WordAw-1:0], 2'b00},
                        (!stat.head_taken && widx_reg < 2) ? 32'hFFFF_FFFF : rd_data,
                        xcfr_pkg::StRun, xcfr_pkg::CauseNone);
                    cmd.head_take0 = !stat.head_taken && widx_reg == 0;
                    cmd.head_take1 = !stat.head_taken && widx_reg == 1;
                    widx_next = widx_reg + 1'b1;
                    if (widx_reg == (xcfr_pkg::WordAw+1)'(xcfr_pkg::WordCount - 1))
                        seq_next = SQ_ACK;
                    else
                    begin
                        cmd.rd_en = 1'b1;
                        cmd.rd_word = widx_next[xcfr_pkg::WordAw-1:0];
                        rd_ok_next = 1'b1;
                    end
                end
                else
                    rd_ok_next = rd_ok_reg;
            end
            SQ_ACK:
            begin
                if (space)
                begin
                    cmd.packet_commit = 1'b1;
                    cmd.exp_inc = 1'b1;
                    cmd.retry_clr = 1'b1;
                    emit = 1'b1; last_next = 1'b1;
                    seq_next = SQ_NONE;
                    od_next = mk(xcfr_pkg::OutTx, xcfr_pkg::ChAck, '0, '0, '0,
                        xcfr_pkg::StRun, xcfr_pkg::CauseNone);
                end
            end
            SQ_HEAD1:
            begin
                if (space)
                begin
                    emit = 1'b1; last_next = 1'b1;
                    seq_next = SQ_NONE;
                    od_next = mk(xcfr_pkg::OutWrite, '0, '0, head_addr + 32'd4, head_w1,
                        xcfr_pkg::StRun, xcfr_pkg::CauseNone);
                end
            end
            default:
            begin
                // session end after CAN or EOT ack
                if (space)
                begin
                    emit = 1'b1; last_next = 1'b1;
                    seq_next = SQ_NONE;
                    od_next = mk(xcfr_pkg::OutEnd, '0, '0, '0, '0,
                        (fcause_reg == xcfr_pkg::CauseNone) ? xcfr_pkg::StSuccess
                                                            : xcfr_pkg::StCan,
                        fcause_reg);
                end
            end
        endcase
        ov_next = emit ? 1'b1 : (out_ready ? 1'b0 : ov_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            seq_reg    <= SQ_NONE;
            widx_reg   <= '0;
            rd_ok_reg  <= 1'b0;
            fcause_reg <= xcfr_pkg::CauseNone;
            ov_reg     <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            seq_reg    <= seq_next;
            widx_reg   <= widx_next;
            rd_ok_reg  <= rd_ok_next;
            fcause_reg <= fcause_next;
            ov_reg     <= ov_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        od_reg <= od_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign out_last  = last_reg;

`ifndef NO_ASSERTIONS
    a_busy_no_in: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg != SQ_NONE |-> !in_ready)
        else $error("input taken during burst");
    a_words_rd: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == SQ_WORDS && $past(seq_reg) == SQ_WORDS && $past(cmd.rd_en)
        |-> rd_ok_reg)
        else $error("read data not flagged");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped while stalled");
`endif

endmodule
`default_nettype wire

FILE: sv/xmodem_crc_flash_receiver_unit.sv
`default_nettype none
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/tready        tdata {rx_byte, kind}
// m_axis    out  m_axis_tvalid/tready        tdata result fields, tlast
// cfg       in   cfg_valid/cfg_ready         cfg_index, cfg_data
// One input transaction per cycle while no result burst is pending and the
// output register is free; a packet end emits up to 34 results, one per cycle
// while the output accepts them, read from the packet store one word a cycle
// (one read port, registered). Reset is asynchronous; it clears control state
// only. Output stalls hold the result register and block input until drained.
module xmodem_crc_flash_receiver_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [15:0]  s_axis_tdata,   // [1:0] kind, [9:2] rx_byte, zero fill
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [135:0]      m_axis_tdata,   // [1:0] out_kind, [9:2] tx_byte,
                                              // [34:10] sector_index, [66:35] write_addr,
                                              // [98:67] write_word, [100:99] status,
                                              // [102:101] error_cause, zero fill
    output logic              m_axis_tlast,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    xcfr_pkg::cmd_t    cmd;
    xcfr_pkg::stat_t   stat;
    xcfr_pkg::result_t od;
    logic [31:0] rd_data, wptr, head_addr, head_w0, head_w1;
    logic [24:0] sector;

    assign cfg_ready = 1'b1;

    xcfr_datapath u_dp (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_val(cfg_data),
        .rx_byte(s_axis_tdata[9:2]), .cmd(cmd), .stat(stat),
        .rd_data(rd_data), .wptr(wptr), .sector(sector),
        .head_addr(head_addr), .head_w0(head_w0), .head_w1(head_w1)
    );

    xcfr_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .kind(s_axis_tdata[1:0]), .rx_byte(s_axis_tdata[9:2]),
        .stat(stat), .cmd(cmd), .rd_data(rd_data), .wptr(wptr), .sector(sector),
        .head_addr(head_addr), .head_w0(head_w0), .head_w1(head_w1),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_data(od), .out_last(m_axis_tlast)
    );

    assign m_axis_tdata = {33'd0, od};

endmodule
`default_nettype wire

FILE: tb/tb_xmodem_crc_flash_receiver_unit.sv
`default_nettype none
module tb_xmodem_crc_flash_receiver_unit;
    import xcfr_pkg::*;

    typedef enum logic [2:0] {
        SIdle, SHdr, SPid, SIpid, SData, SCrc1, SCrc2, SDrain
    } rx_state_t;

    typedef struct {
        result_t r;
        bit      tl;
    } flash_result_t;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] b;
        int         n_typed;   // -1: take the prediction, else typed result count
        logic [1:0] okind;
        logic [7:0] otx;
        logic [1:0] ost;
        logic [1:0] ocause;
    } dir_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [15:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;

    // shadow of the receiver
    logic [31:0] win_start, win_end;
    logic [4:0]  sec_shift;
    rx_state_t   rx_state;
    bit          data_mode;
    logic [7:0]  rx_count, pkt_num, next_num, crc_hi_rx;
    logic [15:0] crc_run;
    logic [7:0]  pkt_mem [PacketBytes];
    logic [3:0]  retries;
    logic [31:0] wr_ptr, last_sector, head_base;
    bit          head_done;
    logic [31:0] head_hold [2];

    flash_result_t flash_q[$];
    flash_result_t pending[$];
    logic [7:0]    payload [PacketBytes];
    int            errors;
    int            items_sent;
    bit            calm;

    xmodem_crc_flash_receiver_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("tb_xmodem_crc_flash_receiver_unit: done, errors");
        $finish;
    end

    function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
        c = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        return c;
    endfunction

    function automatic logic [31:0] mem_word(int i);
        int k;
        k = (i * 4) % PacketBytes;
        return {pkt_mem[k + 3], pkt_mem[k + 2], pkt_mem[k + 1], pkt_mem[k]};
    endfunction

    task automatic add_result(logic [1:0] k, logic [7:0] tx, logic [24:0] sec,
                              logic [31:0] addr, logic [31:0] word,
                              logic [1:0] st, logic [1:0] cause);
        flash_result_t e;
        e.r = '{error_cause: cause, status: st, write_word: word, write_addr: addr,
                sector_index: sec, tx_byte: tx, out_kind: k};
        e.tl = 1'b0;
        pending.push_back(e);
    endtask

    task automatic abort_session(logic [1:0] cause);
        add_result(OutTx, ChCan, '0, '0, '0, StRun, CauseNone);
        rx_state = SIdle;
        add_result(OutEnd, '0, '0, '0, '0, StCan, cause);
    endtask

    task automatic close_packet();
        logic [31:0] sec, w;
        if (!data_mode)
        begin
            if (pkt_num != 8'd0)
                rx_state = SDrain;
            else if (mem_word(0) > win_end - win_start)
                abort_session(CauseSize);
            else
            begin
                next_num = 8'd1;
                retries = '0;
                data_mode = 1'b1;
                rx_state = SHdr;
                add_result(OutTx, ChAck, '0, '0, '0, StRun, CauseNone);
            end
            return;
        end
        if (pkt_num != next_num)
            rx_state = SDrain;
        else if (wr_ptr + 32'(PacketBytes) > win_end)
            abort_session(CauseAddr);
        else
        begin
            sec = wr_ptr >> sec_shift;
            if (sec != last_sector)
            begin
                add_result(OutErase, '0, sec[24:0], '0, '0, StRun, CauseNone);
                last_sector = sec;
            end
            for (int i = 0; i < WordCount; i++)
            begin
                w = mem_word(i);
                if (!head_done && i < 2)
                begin
                    head_hold[i] = w;
                    w = 32'hFFFF_FFFF;
                end
                add_result(OutWrite, '0, '0, wr_ptr + 32'(4 * i), w, StRun, CauseNone);
            end
            head_done = 1'b1;
            wr_ptr += 32'(PacketBytes);
            next_num++;
            retries = '0;
            rx_state = SHdr;
            add_result(OutTx, ChAck, '0, '0, '0, StRun, CauseNone);
        end
    endtask

    // advance the shadow by one accepted input; results land in pending
    task automatic predict_flash(logic [1:0] kind, logic [7:0] b);
        pending.delete();
        case (kind)
            KindStart:
            begin
                data_mode = 1'b0;
                retries = '0;
                next_num = '0;
                wr_ptr = win_start;
                head_base = win_start;
                last_sector = '0;
                head_done = 1'b0;
                rx_state = SHdr;
                add_result(OutTx, ChNak, '0, '0, '0, StRun, CauseNone);
            end
            KindByte:
            case (rx_state)
                SHdr:
                    if (b == ChSoh)
                        rx_state = SPid;
                    else if (b == ChEot && data_mode)
                    begin
                        add_result(OutTx, ChAck, '0, '0, '0, StRun, CauseNone);
                        rx_state = SIdle;
                        add_result(OutEnd, '0, '0, '0, '0, StSuccess, CauseNone);
                    end
                    else
                        rx_state = SDrain;
                SPid:
                begin
                    pkt_num = b;
                    rx_state = SIpid;
                end
                SIpid:
                    if (pkt_num != ~b)
                        rx_state = SDrain;
                    else
                    begin
                        rx_count = '0;
                        crc_run = '0;
                        rx_state = SData;
                    end
                SData:
                begin
                    pkt_mem[rx_count[6:0]] = b;
                    crc_run = crc16_step(crc_run, b);
                    rx_count++;
                    if (rx_count >= 8'(PacketBytes))
                        rx_state = SCrc1;
                end
                SCrc1:
                begin
                    crc_hi_rx = b;
                    rx_state = SCrc2;
                end
                SCrc2:
                    if (crc_hi_rx == crc_run[15:8] && b == crc_run[7:0])
                        close_packet();
                    else
                        rx_state = SDrain;
                default:
                    ;
            endcase
            KindTimeout:
                if (rx_state == SDrain)
                begin
                    retries++;
                    if (retries > RetryLimit)
                    begin
                        if (data_mode)
                            abort_session(CauseRetry);
                        else
                        begin
                            rx_state = SIdle;
                            add_result(OutEnd, '0, '0, '0, '0, StGaveUp, CauseRetry);
                        end
                    end
                    else
                    begin
                        rx_state = SHdr;
                        add_result(OutTx, ChNak, '0, '0, '0, StRun, CauseNone);
                    end
                end
                else if (rx_state != SIdle)
                    rx_state = SDrain;
            default:
            begin
                add_result(OutWrite, '0, '0, head_base, head_hold[0], StRun, CauseNone);
                add_result(OutWrite, '0, '0, head_base + 32'd4, head_hold[1], StRun,
                           CauseNone);
            end
        endcase
        if (pending.size() > 0)
            pending[pending.size() - 1].tl = 1'b1;
    endtask

    // valid stays high into the next transaction unless an idle cycle drops it
    task automatic send_raw(logic [1:0] kind, logic [7:0] b);
        while (!calm && $urandom_range(99) < 18)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, b, kind};
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_item(logic [1:0] kind, logic [7:0] b);
        send_raw(kind, b);
        predict_flash(kind, b);
        foreach (pending[i])
            flash_q.push_back(pending[i]);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (flash_q.size() > 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            RegStart: win_start = val;
            RegEnd:   win_end = val;
            default:  sec_shift = val[4:0];
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mode: 0 clean, 1 bad crc, 2 bad complement, 3 cut short by a timeout
    task automatic send_packet(logic [7:0] num, int mode);
        logic [15:0] crc;
        crc = '0;
        send_item(KindByte, ChSoh);
        send_item(KindByte, num);
        send_item(KindByte, mode == 2 ? num : ~num);
        for (int i = 0; i < PacketBytes; i++)
        begin
            if (mode == 3 && i == 40)
            begin
                send_item(KindTimeout, '0);
                return;
            end
            send_item(KindByte, payload[i]);
            crc = crc16_step(crc, payload[i]);
        end
        if (mode == 1)
            crc ^= 16'(1 << $urandom_range(15));
        send_item(KindByte, crc[15:8]);
        send_item(KindByte, crc[7:0]);
    endtask

    task automatic fill_payload(logic [31:0] size);
        foreach (payload[i])
            payload[i] = 8'($urandom);
        {payload[3], payload[2], payload[1], payload[0]} = size;
    endtask

    task automatic run_session(int n_pkts, bit oversize);
        logic [7:0] num;
        int         mode;
        send_item(KindStart, '0);
        fill_payload(oversize ? win_end - win_start + 32'd1 + 32'($urandom_range(9))
                              : 32'($urandom_range(PacketBytes * n_pkts)));
        send_packet(8'd0, $urandom_range(9) < 2 ? 1 : 0);
        if (rx_state == SDrain || rx_state == SCrc2)
        begin
            send_item(KindTimeout, '0);
            if (rx_state == SHdr)
                send_packet(8'd0, 0);
        end
        num = 8'd1;
        for (int p = 0; p < n_pkts && rx_state == SHdr; p++)
        begin
            fill_payload(32'($urandom));
            mode = $urandom_range(9);
            if (mode < 3)
            begin
                send_packet(mode == 0 ? num - 8'd1 : num, mode == 0 ? 0 : mode);
                if (rx_state != SDrain)
                    send_item(KindTimeout, '0);
                if ($urandom_range(3) == 0)
                    send_item(KindByte, 8'($urandom));
                send_item(KindTimeout, '0);
            end
            if (rx_state == SHdr)
            begin
                send_packet(num, 0);
                num++;
            end
        end
        if ($urandom_range(3) == 0)
            send_item(KindFinish, '0);
        if (rx_state == SHdr && $urandom_range(4) != 0)
            send_item(KindByte, ChEot);
        else
            while (rx_state != SIdle)
                send_item(KindTimeout, '0);
    endtask

    // result side: random stalls, compare in order
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (flash_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result %h", m_axis_tdata);
                end
                else
                begin
                    flash_result_t e;
                    e = flash_q.pop_front();
                    if (m_axis_tdata !== {33'd0, e.r} || m_axis_tlast !== e.tl)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %h/%b actual %h/%b",
                                     {33'd0, e.r}, e.tl, m_axis_tdata, m_axis_tlast);
                    end
                end
            end
            @(negedge clk);
            m_axis_tready <= calm || ($urandom_range(99) >= 18);
        end
    end

    initial
    begin
        dir_row_t rows[$];
        int       wait_cycles;
        rows = '{
            '{KindTimeout, 8'h00, 0, OutTx, 8'h00, StRun, CauseNone},
            '{KindByte,    8'h01, 0, OutTx, 8'h00, StRun, CauseNone},
            '{KindFinish,  8'h00, -1, OutTx, 8'h00, StRun, CauseNone},
            '{KindStart,   8'h00, 1, OutTx, ChNak, StRun, CauseNone},
            '{KindByte,    ChEot, 0, OutTx, 8'h00, StRun, CauseNone},
            '{KindByte,    8'hFF, 0, OutTx, 8'h00, StRun, CauseNone},
            '{KindTimeout, 8'h00, 1, OutTx, ChNak, StRun, CauseNone},
            '{KindByte,    8'h00, 0, OutTx, 8'h00, StRun, CauseNone},
            '{KindTimeout, 8'h00, 1, OutTx, ChNak, StRun, CauseNone},
            '{KindByte,    ChSoh, 0, OutTx, 8'h00, StRun, CauseNone},
            '{KindByte,    8'h05, 0, OutTx, 8'h00, StRun, CauseNone},
            '{KindByte,    8'h00, 0, OutTx, 8'h00, StRun, CauseNone},
            '{KindTimeout, 8'hAA, 1, OutTx, ChNak, StRun, CauseNone},
            '{KindTimeout, 8'h00, 0, OutTx, 8'h00, StRun, CauseNone},
            '{KindTimeout, 8'h00, 1, OutTx, ChNak, StRun, CauseNone},
            '{KindTimeout, 8'h00, 0, OutTx, 8'h00, StRun, CauseNone},
            '{KindTimeout, 8'h00, 1, OutTx, ChNak, StRun, CauseNone},
            '{KindTimeout, 8'h00, 0, OutTx, 8'h00, StRun, CauseNone},
            '{KindTimeout, 8'h00, 1, OutEnd, 8'h00, StGaveUp, CauseRetry},
            '{KindStart,   8'h00, 1, OutTx, ChNak, StRun, CauseNone},
            '{KindFinish,  8'h55, -1, OutTx, 8'h00, StRun, CauseNone}
        };
        errors = 0;
        items_sent = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = RegStart;
        cfg_data = '0;
        win_start = '0;
        win_end = '0;
        sec_shift = 5'd10;
        rx_state = SIdle;
        data_mode = 1'b0;
        rx_count = '0;
        pkt_num = 8'hFF;
        next_num = '0;
        crc_run = '0;
        crc_hi_rx = '0;
        retries = '0;
        wr_ptr = '0;
        last_sector = '0;
        head_base = '0;
        head_done = 1'b0;
        head_hold[0] = '0;
        head_hold[1] = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            send_raw(rows[i].kind, rows[i].b);
            predict_flash(rows[i].kind, rows[i].b);
            if (rows[i].n_typed < 0)
            begin
                foreach (pending[j])
                    flash_q.push_back(pending[j]);
            end
            else if (rows[i].n_typed == 1)
            begin
                flash_result_t e;
                e.r = '{error_cause: rows[i].ocause, status: rows[i].ost,
                        write_word: '0, write_addr: '0, sector_index: '0,
                        tx_byte: rows[i].otx, out_kind: rows[i].okind};
                e.tl = 1'b1;
                flash_q.push_back(e);
            end
        end
        // finish the open session by giving up
        while (rx_state != SIdle)
            send_item(KindTimeout, '0);

        // full window at the top of the address space, smallest sectors
        write_reg(RegStart, 32'hFFFF_FE00);
        write_reg(RegEnd, 32'hFFFF_FFFF);
        write_reg(RegShift, 32'd7);
        run_session(1, 1'b0);
        // pause until the block has caught up
        drain_results();
        // window too small for the file, with no idling on either side
        write_reg(RegStart, 32'h0000_0000);
        write_reg(RegEnd, 32'h0000_0100);
        write_reg(RegShift, 32'd20);
        calm = 1'b1;
        run_session(0, 1'b1);
        calm = 1'b0;

        while (items_sent < 460)
        begin
            if ($urandom_range(1))
            begin
                write_reg(RegStart, $urandom_range(3) == 0 ? 32'($urandom)
                                    : 32'($urandom_range(4095)) << 7);
                write_reg(RegEnd, win_start + 32'($urandom_range(PacketBytes * 5)));
                write_reg(RegShift, 32'($urandom_range(20, 7)));
            end
            run_session($urandom_range(1), $urandom_range(9) == 0);
        end
        s_axis_tvalid <= 1'b0;

        wait_cycles = 0;
        while (flash_q.size() > 0 && wait_cycles < 20000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (50) @(negedge clk);
        if (errors == 0 && flash_q.size() == 0)
            $display("tb_xmodem_crc_flash_receiver_unit: done, clean");
        else
            $display("tb_xmodem_crc_flash_receiver_unit: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
